// File: rtl/smj_pkg.sv
// Package with the shared types and constants of the sort-merge join probe.
package smj_pkg;

  localparam int unsigned S_DEPTH    = 1024;
  localparam int unsigned S_AW       = $clog2(S_DEPTH);
  localparam int unsigned FILL_W     = S_AW + 1;
  localparam int unsigned MAX_EMIT   = 64;
  localparam int unsigned EMIT_W     = $clog2(MAX_EMIT + 1);
  localparam int unsigned EB_AW      = (MAX_EMIT > 1) ? $clog2(MAX_EMIT) : 1;
  localparam int unsigned OTHER_KEYS = 2;
  localparam int unsigned CNT_W      = 11;
  localparam int unsigned IN_W       = 136;
  localparam int unsigned OUT_W      = 208;

  localparam logic CFG_OTHER_KEY_COUNT = 1'b0;
  localparam logic CFG_EMIT_PAIRS      = 1'b1;

  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_APPEND = 2'd1,
    OP_PROBE  = 2'd2,
    OP_NONE   = 2'd3
  } opcode_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_ORDER    = 2'd2,
    ST_OVERFLOW = 2'd3
  } status_e;

  typedef struct packed {
    logic [31:0] payload;
    logic [31:0] attr_b;
    logic [31:0] attr_a;
    logic [31:0] key;
    opcode_e     opcode;
  } item_t;

  typedef struct packed {
    logic [31:0]      total_count;
    logic [CNT_W-1:0] match_count;
    logic [31:0]      s_payload;
    logic [31:0]      r_payload;
    logic [31:0]      attr_b;
    logic [31:0]      attr_a;
    logic [31:0]      join_key;
    status_e          status;
  } result_t;

  typedef struct packed {
    logic [31:0] payload;
    logic [31:0] attr_b;
    logic [31:0] attr_a;
    logic [31:0] key;
  } s_entry_t;

endpackage

// File: rtl/sort_merge_join_probe.sv
// Top level of the sort-merge join probe: stream ports, front queue and back end.
// Input stream s_axis: one transaction per clear, append or probe item. Opcode 3
// is dropped at the input and gives no result.
// Output stream m_axis: result transactions; tlast marks the final result of an item.
// Configuration: cfg_we_i writes cfg_data_i to register cfg_idx_i at a clock edge;
// registers must be written only while the block is idle (not enforced by the block).
// A clear or append item gives its single result on m_axis through the queue and the
// output register. A probe whose key is below the previous probe key gets an order
// error result without a scan; any other probe walks the table from its kept scan
// start one entry at a time, a read state then a compare state, using the single read
// port of the table memory, until the first larger key or the end of the filled part,
// then gives a count or no-match result, or its pairs. Pair results are held in a
// 64-entry buffer and leave only once the scan ends, since each carries the final total.
// A two-entry queue decouples input acceptance from execution; s_axis_tready drops
// when it is full. When the receiver stalls, the output register holds its result and
// the back end waits. Reset empties the table, the queue and the output register and
// loads the register defaults. The table memory needs no clearing pass.
module sort_merge_join_probe import smj_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic             cfg_idx_i,
  input  logic [1:0]       cfg_data_i,
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  // opcode, key_in, attr_a_in, attr_b_in, payload_in, zero fill
  input  logic [IN_W-1:0]  s_axis_tdata,
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  // status, join_key_out, attr_a_out, attr_b_out, r_payload_out, s_payload_out,
  // match_count, total_count, zero fill
  output logic [OUT_W-1:0] m_axis_tdata,
  output logic             m_axis_tlast
);

  item_t   in_item, q_item;
  result_t res;
  logic    q_valid, q_pop;

  assign in_item = item_t'(s_axis_tdata[$bits(item_t)-1:0]);

  smj_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_item_i  (in_item),
    .q_valid_o  (q_valid),
    .q_pop_i    (q_pop),
    .q_item_o   (q_item)
  );

  smj_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .q_valid_i   (q_valid),
    .q_pop_o     (q_pop),
    .q_item_i    (q_item),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_res_o   (res),
    .out_last_o  (m_axis_tlast)
  );

  assign m_axis_tdata = {{(OUT_W - $bits(result_t)){1'b0}}, res};

endmodule

// File: rtl/smj_front.sv
// Front end: accepts input transactions, drops unknown opcodes and queues the rest.
module smj_front import smj_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  input  item_t in_item_i,
  output logic  q_valid_o,
  input  logic  q_pop_i,
  output item_t q_item_o
);

  item_t      mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;
  logic       push;

  assign in_ready_o = (cnt_q != 2'd2);
  assign push       = in_valid_i && in_ready_o && (in_item_i.opcode != OP_NONE);
  assign q_valid_o  = (cnt_q != 2'd0);
  assign q_item_o   = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= in_item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (q_pop_i) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, q_pop_i};
    end
  end

`ifndef ASSERT_OFF
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q != 2'd3)
    else $error("queue count out of range");
  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop_i |-> cnt_q != 2'd0)
    else $error("pop from empty queue");
`endif

endmodule

// File: rtl/smj_back.sv
// Back end: table storage, scan engine, pair buffer and output register.
module smj_back import smj_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [1:0]  cfg_data_i,
  input  logic        q_valid_i,
  output logic        q_pop_o,
  input  item_t       q_item_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output result_t     out_res_o,
  output logic        out_last_o
);

  typedef enum logic [5:0] {
    S_IDLE     = 6'b000001,
    S_SCAN_RD  = 6'b000010,
    S_SCAN_CMP = 6'b000100,
    S_DONE     = 6'b001000,
    S_EMIT_RD  = 6'b010000,
    S_EMIT_OUT = 6'b100000
  } state_e;

  state_e state_q, state_d;

  s_entry_t          s_mem [S_DEPTH];
  logic [31:0]       eb_mem [MAX_EMIT];
  s_entry_t          rd_q;
  logic [31:0]       eb_rd_q;

  logic [1:0]        okc_q;
  logic              pairs_q;
  logic [FILL_W-1:0] fill_q, fill_d, start_q, start_d, stop_q, stop_d, i_q, i_d;
  logic [31:0]       prev_q, prev_d, last_key_q, last_key_d, total_q, total_d;
  logic              seen_q, seen_d;
  item_t             r_q, r_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic [EMIT_W-1:0] emitted_q, emitted_d;
  logic [EB_AW-1:0]  e_q, e_d;
  logic              out_valid_q, out_last_q, out_last_d, out_load;
  result_t           out_q, out_d;

  logic              out_free, s_we, eb_we, s_re, eb_re, attr_ok, key_eq, key_lt;
  logic [FILL_W-1:0] start_sel;
  logic [1:0]        nk;
  logic              is_last, overflow;

  assign out_free = !out_valid_q || out_ready_i;
  assign nk       = (okc_q > 2'd2) ? 2'd2 :
                    ((okc_q > 2'(OTHER_KEYS)) ? 2'(OTHER_KEYS) : okc_q);
  assign key_eq   = (rd_q.key == r_q.key);
  assign key_lt   = ($signed(r_q.key) < $signed(rd_q.key));
  assign attr_ok  = ((nk < 2'd1) || (rd_q.attr_a == r_q.attr_a)) &&
                    ((nk < 2'd2) || (rd_q.attr_b == r_q.attr_b));
  assign is_last  = ({1'b0, e_q} == EMIT_W'(emitted_q - EMIT_W'(1)));
  assign overflow = (count_q > CNT_W'(MAX_EMIT));

  always_comb begin
    state_d    = state_q;
    fill_d     = fill_q;
    start_d    = start_q;
    stop_d     = stop_q;
    i_d        = i_q;
    prev_d     = prev_q;
    last_key_d = last_key_q;
    total_d    = total_q;
    seen_d     = seen_q;
    r_d        = r_q;
    count_d    = count_q;
    emitted_d  = emitted_q;
    e_d        = e_q;
    out_load   = 1'b0;
    out_d      = '0;
    out_last_d = 1'b1;
    q_pop_o    = 1'b0;
    s_we       = 1'b0;
    s_re       = 1'b0;
    eb_we      = 1'b0;
    eb_re      = 1'b0;
    start_sel  = start_q;
    case (state_q)
      S_IDLE: begin
        if (q_valid_i && out_free) begin
          q_pop_o = 1'b1;
          r_d     = q_item_i;
          case (q_item_i.opcode)
            OP_CLEAR: begin
              fill_d   = '0;
              start_d  = '0;
              stop_d   = '0;
              prev_d   = '0;
              seen_d   = 1'b0;
              total_d  = '0;
              out_load = 1'b1;
            end
            OP_APPEND: begin
              out_load          = 1'b1;
              out_d.total_count = total_q;
              if (fill_q >= FILL_W'(S_DEPTH)) begin
                out_d.status = ST_FULL;
              end else if ((fill_q != '0) &&
                           ($signed(q_item_i.key) < $signed(last_key_q))) begin
                out_d.status = ST_ORDER;
              end else begin
                s_we       = 1'b1;
                fill_d     = fill_q + FILL_W'(1);
                last_key_d = q_item_i.key;
              end
            end
            OP_PROBE: begin
              if (seen_q && ($signed(q_item_i.key) < $signed(prev_q))) begin
                out_load          = 1'b1;
                out_d.status      = ST_ORDER;
                out_d.total_count = total_q;
              end else begin
                if (seen_q && (q_item_i.key != prev_q)) begin
                  start_sel = stop_q;
                end
                if (start_sel > fill_q) begin
                  start_sel = fill_q;
                end
                start_d   = start_sel;
                i_d       = start_sel;
                count_d   = '0;
                emitted_d = '0;
                prev_d    = q_item_i.key;
                seen_d    = 1'b1;
                state_d   = S_SCAN_RD;
              end
            end
            default: ;
          endcase
        end
      end
      S_SCAN_RD: begin
        if (i_q < fill_q) begin
          s_re    = 1'b1;
          state_d = S_SCAN_CMP;
        end else begin
          stop_d  = i_q;
          state_d = S_DONE;
        end
      end
      S_SCAN_CMP: begin
        if (key_eq) begin
          if (attr_ok) begin
            count_d = count_q + CNT_W'(1);
            total_d = total_q + 32'd1;
            if (pairs_q && (emitted_q < EMIT_W'(MAX_EMIT))) begin
              eb_we     = 1'b1;
              emitted_d = emitted_q + EMIT_W'(1);
            end
          end
          i_d     = i_q + FILL_W'(1);
          state_d = S_SCAN_RD;
        end else if (key_lt) begin
          stop_d  = i_q;
          state_d = S_DONE;
        end else begin
          i_d     = i_q + FILL_W'(1);
          state_d = S_SCAN_RD;
        end
      end
      S_DONE: begin
        if (!pairs_q || (emitted_q == '0)) begin
          if (out_free) begin
            out_load          = 1'b1;
            out_d.join_key    = r_q.key;
            out_d.attr_a      = r_q.attr_a;
            out_d.attr_b      = r_q.attr_b;
            out_d.r_payload   = r_q.payload;
            out_d.match_count = pairs_q ? '0 : count_q;
            out_d.total_count = total_q;
            state_d           = S_IDLE;
          end
        end else begin
          e_d     = '0;
          state_d = S_EMIT_RD;
        end
      end
      S_EMIT_RD: begin
        eb_re   = 1'b1;
        state_d = S_EMIT_OUT;
      end
      S_EMIT_OUT: begin
        if (out_free) begin
          out_load          = 1'b1;
          out_d.join_key    = r_q.key;
          out_d.attr_a      = r_q.attr_a;
          out_d.attr_b      = r_q.attr_b;
          out_d.r_payload   = r_q.payload;
          out_d.s_payload   = eb_rd_q;
          out_d.total_count = total_q;
          out_d.match_count = CNT_W'({1'b0, e_q} + EMIT_W'(1));
          out_last_d        = is_last;
          if (is_last && overflow) begin
            out_d.status      = ST_OVERFLOW;
            out_d.match_count = count_q;
          end
          if (is_last) begin
            state_d = S_IDLE;
          end else begin
            e_d     = e_q + EB_AW'(1);
            state_d = S_EMIT_RD;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (s_we) begin
      s_mem[fill_q[S_AW-1:0]] <= '{payload: q_item_i.payload, attr_b: q_item_i.attr_b,
                                   attr_a: q_item_i.attr_a, key: q_item_i.key};
    end
    if (s_re) begin
      rd_q <= s_mem[i_q[S_AW-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (eb_we) begin
      eb_mem[emitted_q[EB_AW-1:0]] <= rd_q.payload;
    end
    if (eb_re) begin
      eb_rd_q <= eb_mem[e_q];
    end
  end

  always_ff @(posedge clk_i) begin
    r_q       <= r_d;
    count_q   <= count_d;
    emitted_q <= emitted_d;
    e_q       <= e_d;
    i_q       <= i_d;
    if (out_load) begin
      out_q      <= out_d;
      out_last_q <= out_last_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      okc_q       <= 2'd0;
      pairs_q     <= 1'b1;
      fill_q      <= '0;
      start_q     <= '0;
      stop_q      <= '0;
      prev_q      <= '0;
      last_key_q  <= '0;
      total_q     <= '0;
      seen_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      fill_q     <= fill_d;
      start_q    <= start_d;
      stop_q     <= stop_d;
      prev_q     <= prev_d;
      last_key_q <= last_key_d;
      total_q    <= total_d;
      seen_q     <= seen_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_OTHER_KEY_COUNT: okc_q   <= cfg_data_i;
          CFG_EMIT_PAIRS:      pairs_q <= cfg_data_i[0];
          default: ;
        endcase
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_res_o   = out_q;
  assign out_last_o  = out_last_q;

`ifndef ASSERT_OFF
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FILL_W'(S_DEPTH))
    else $error("table fill exceeds depth");
  a_emit_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != S_IDLE |-> emitted_q <= EMIT_W'(MAX_EMIT))
    else $error("pair buffer overrun");
  a_cmp_after_rd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_SCAN_CMP |-> $past(state_q) == S_SCAN_RD)
    else $error("compare without table read");
  a_scan_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_SCAN_CMP |-> i_q < fill_q)
    else $error("scan index beyond fill");
`endif

endmodule
